>>> sv/fisheye_ray_direction_defines.svh
// Assertion macros for the fisheye ray direction block.
// Used by the top level; no other dependencies.
`ifndef FISHEYE_RAY_DIRECTION_DEFINES_SVH
`define FISHEYE_RAY_DIRECTION_DEFINES_SVH
`ifndef SYNTHESIS
`define FRD_ASSERT_IMPL(label, clock, rstn, pre, post) \
	label: assert property (@(posedge clock) disable iff (!rstn) (pre) |-> (post)) \
		else $error("frd assertion failed");
`define FRD_ASSERT_NEXT(label, clock, rstn, pre, post) \
	label: assert property (@(posedge clock) disable iff (!rstn) (pre) |=> (post)) \
		else $error("frd assertion failed");
`else
`define FRD_ASSERT_IMPL(label, clock, rstn, pre, post)
`define FRD_ASSERT_NEXT(label, clock, rstn, pre, post)
`endif
`endif

>>> sv/frd_pkg.sv
// frd_pkg: widths, constants, register codes, bundle types and small helper
// functions for the fisheye ray direction pipeline. No dependencies.
`timescale 1ns / 1ps
package frd_pkg;

	localparam int MAG_W = 29;   // normalized axis magnitude, Q.24, capped at 16.0
	localparam int NUM_W = 57;   // normalization dividend |p| << 25
	localparam int DIV_W = 45;   // pixel_size * resolution
	localparam int SUM_W = 58;   // nx^2 + ny^2, Q.48
	localparam int QUO_W = 31;   // alpha term quotient, Q.30
	localparam int PRD_W = 59;   // |sin| * magnitude
	localparam int CRD_W = 33;   // CORDIC datapath, signed Q.30
	localparam int TRM_W = 32;   // clamped sin/cos and alpha terms

	localparam logic [2:0] REG_FOV     = 3'd0;
	localparam logic [2:0] REG_HPIX    = 3'd1;
	localparam logic [2:0] REG_VPIX    = 3'd2;
	localparam logic [2:0] REG_PSIZE   = 3'd3;
	localparam logic [2:0] REG_BASIS_U = 3'd4;
	localparam logic [2:0] REG_BASIS_V = 3'd5;
	localparam logic [2:0] REG_BASIS_W = 3'd6;

	localparam logic [MAG_W-1:0] MAG_CAP  = 29'h1000_0000;
	localparam logic [24:0]      ROOT_CAP = 25'h100_0000;
	localparam logic [23:0]      R2_MAX   = 24'hFF_FFFF;
	localparam logic [23:0]      R2_ONE   = 24'h01_0000;

	localparam logic [24:0] DEG90  = 25'd5898240;
	localparam logic [24:0] DEG180 = 25'd11796480;
	localparam logic [24:0] DEG270 = 25'd17694720;
	localparam logic [24:0] DEG360 = 25'd23592960;

	// pi/180 in Q.44, split so that each partial product stays narrow
	localparam logic [38:0] RAD_PER_DEG = 39'd307041569101;
	localparam logic [18:0] RAD_HI = RAD_PER_DEG[38:20];
	localparam logic [19:0] RAD_LO = RAD_PER_DEG[19:0];

	localparam logic signed [CRD_W-1:0] CORDIC_GAIN = 33'sd652032874;
	localparam logic signed [CRD_W-1:0] ONE_Q30     = 33'sd1073741824;
	localparam logic [QUO_W-1:0]        ONE_Q30_U   = 31'h4000_0000;

	typedef struct packed {
		logic [MAG_W-1:0] mx;
		logic [MAG_W-1:0] my;
		logic             neg_x;
		logic             neg_y;
		logic [23:0]      r2;
		logic             in_disc;
		logic [MAG_W-1:0] root;
	} side_t;

	typedef struct packed {
		logic [NUM_W-1:0] rem_x;
		logic [NUM_W-1:0] rem_y;
		logic [MAG_W-1:0] q_x;
		logic [MAG_W-1:0] q_y;
		logic             sat_x;
		logic             sat_y;
		logic             neg_x;
		logic             neg_y;
	} nrm_t;

	typedef struct packed {
		logic [SUM_W-1:0] rem;
		logic [MAG_W-1:0] root;
		logic [MAG_W-1:0] mx;
		logic [MAG_W-1:0] my;
		logic             neg_x;
		logic             neg_y;
		logic [23:0]      r2;
		logic             in_disc;
	} rt_t;

	typedef struct packed {
		logic signed [CRD_W-1:0] x;
		logic signed [CRD_W-1:0] y;
		logic signed [CRD_W-1:0] z;
		logic [1:0]              quad;
		side_t                   side;
	} cor_t;

	typedef struct packed {
		logic [PRD_W-1:0]        rem_a;
		logic [PRD_W-1:0]        rem_b;
		logic [QUO_W-1:0]        q_a;
		logic [QUO_W-1:0]        q_b;
		logic                    neg_a;
		logic                    neg_b;
		logic signed [TRM_W-1:0] cp;
		logic [MAG_W-1:0]        root;
		logic [23:0]             r2;
		logic                    in_disc;
	} qt_t;

	function automatic logic signed [CRD_W-1:0] atan_step(input int i);
		logic signed [CRD_W-1:0] a;
		case (i)
			0:       a = 33'sd843314857;
			1:       a = 33'sd497837829;
			2:       a = 33'sd263043837;
			3:       a = 33'sd133525159;
			4:       a = 33'sd67021687;
			5:       a = 33'sd33543516;
			6:       a = 33'sd16775851;
			7:       a = 33'sd8388437;
			8:       a = 33'sd4194283;
			9:       a = 33'sd2097149;
			10:      a = 33'sd1048575;
			default: a = 33'sd1 <<< (30 - i);
		endcase
		return a;
	endfunction

	function automatic logic signed [TRM_W-1:0] clamp_q30(input logic signed [CRD_W-1:0] v);
		logic signed [CRD_W-1:0] c;
		c = v;
		if (v > ONE_Q30)
			c = ONE_Q30;
		else if (v < -ONE_Q30)
			c = -ONE_Q30;
		return TRM_W'(c);
	endfunction

endpackage

>>> sv/fisheye_ray_direction.sv
// Fisheye camera ray generator. Takes one view-plane point per item and returns the
// ray direction, the squared normalized radius and an inside-disc flag. Fully pipelined:
// one item per clock while the output is not stalled. Latency is set by the
// bit-per-stage normalization divider (30 stages), root extraction (29), CORDIC (one
// stage per iteration) and the alpha divider (31). A skid register behind the output
// register takes the item that leaves the pipe in the cycle a stall begins; the input
// stalls while it is full. The divisors derived from the configuration are registered
// again from the stored settings; write only while no item is in flight. Depends on
// frd_pkg and fisheye_ray_direction_defines.svh.
`timescale 1ns / 1ps
`include "fisheye_ray_direction_defines.svh"
module fisheye_ray_direction #(
	parameter int CORDIC_ITERATIONS = 18
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,    // plane_x [31:0], plane_y [63:32]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,    // dir_x [19:0], dir_y [39:20], dir_z [59:40],
	                                // radius_squared [83:60], zero pad
	output logic        m_tuser,    // inside_disc
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [59:0] cfg_data
);
	import frd_pkg::*;

	localparam int NI    = (CORDIC_ITERATIONS > 30) ? 30 : CORDIC_ITERATIONS;
	localparam int DEPTH = 104 + NI;

	logic [24:0]      fov_q;
	logic [12:0]      hpix_q, vpix_q;
	logic [31:0]      psize_q;
	logic [59:0]      bu_q, bv_q, bw_q;
	logic [DIV_W-1:0] dvx_q, dvy_q;

	logic             ce;
	logic [DEPTH-1:0] vld_s;

	nrm_t             nrm_s [0:30];
	logic [MAG_W-1:0] mx_mg_s, my_mg_s;
	logic             nx_mg_s, ny_mg_s;
	logic [SUM_W-1:0] px_sq_s, py_sq_s;
	logic [MAG_W-1:0] mx_sq_s, my_sq_s;
	logic             nx_sq_s, ny_sq_s;
	rt_t              rt_s [0:29];
	logic [24:0]      psi_ps_s;
	side_t            sd_ps_s;
	logic [24:0]      psi_wr_s;
	side_t            sd_wr_s;
	logic [1:0]       quad_qd_s;
	logic [22:0]      rem_qd_s;
	side_t            sd_qd_s;
	logic [41:0]      phi_t1_s;
	logic [42:0]      plo_t1_s;
	logic [1:0]       quad_t1_s;
	side_t            sd_t1_s;
	cor_t             cor_s [0:NI];
	logic signed [TRM_W-1:0] cp_cl_s, sp_cl_s;
	side_t            sd_cl_s;
	qt_t              qt_s [0:31];
	logic signed [51:0] mu_ml_s [3];
	logic signed [51:0] mv_ml_s [3];
	logic signed [51:0] mw_ml_s [3];
	logic [23:0]      r2_ml_s;
	logic             in_ml_s;
	logic signed [53:0] acc_ac_s [3];
	logic [23:0]      r2_ac_s;
	logic             in_ac_s;
	logic [87:0]      p_data_s;
	logic             p_user_s;

	logic             out_valid_q, skid_valid_q;
	logic [87:0]      out_data_q, skid_data_q;
	logic             out_user_q, skid_user_q;

	// ---------------- configuration ----------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fov_q   <= 25'd11796480;
			hpix_q  <= 13'd256;
			vpix_q  <= 13'd256;
			psize_q <= 32'd65536;
			bu_q    <= 60'd262144;
			bv_q    <= 60'd274877906944;
			bw_q    <= 60'd288230376151711744;
			dvx_q   <= 45'd16777216;
			dvy_q   <= 45'd16777216;
		end else begin
			dvx_q <= psize_q * hpix_q;
			dvy_q <= psize_q * vpix_q;
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_FOV:     fov_q   <= cfg_data[24:0];
					REG_HPIX:    hpix_q  <= cfg_data[12:0];
					REG_VPIX:    vpix_q  <= cfg_data[12:0];
					REG_PSIZE:   psize_q <= cfg_data[31:0];
					REG_BASIS_U: bu_q    <= cfg_data;
					REG_BASIS_V: bv_q    <= cfg_data;
					REG_BASIS_W: bw_q    <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// ---------------- flow control ----------------
	assign ce       = !skid_valid_q;
	assign s_tready = ce;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (ce)
			vld_s <= {vld_s[DEPTH-2:0], s_tvalid};
	end

	// ---------------- normalization divider ----------------
	always_ff @(posedge clk) begin
		logic [31:0] ax, ay;
		nrm_t nd;
		if (ce) begin
			ax = s_tdata[31] ? (32'd0 - s_tdata[31:0]) : s_tdata[31:0];
			ay = s_tdata[63] ? (32'd0 - s_tdata[63:32]) : s_tdata[63:32];
			nrm_s[0].rem_x <= {ax, 25'd0};
			nrm_s[0].rem_y <= {ay, 25'd0};
			nrm_s[0].q_x   <= '0;
			nrm_s[0].q_y   <= '0;
			nrm_s[0].sat_x <= 1'b0;
			nrm_s[0].sat_y <= 1'b0;
			nrm_s[0].neg_x <= s_tdata[31];
			nrm_s[0].neg_y <= s_tdata[63];

			// quotient at or above 2^29 saturates; also covers a zero divisor
			nd       = nrm_s[0];
			nd.sat_x = (nrm_s[0].rem_x >> 29) >= {12'd0, dvx_q};
			nd.sat_y = (nrm_s[0].rem_y >> 29) >= {12'd0, dvy_q};
			nrm_s[1] <= nd;

			for (int k = 2; k <= 30; k++) begin
				nd = nrm_s[k-1];
				if ((nrm_s[k-1].rem_x >> (30 - k)) >= {12'd0, dvx_q}) begin
					nd.rem_x = nrm_s[k-1].rem_x - ({12'd0, dvx_q} << (30 - k));
					nd.q_x[30-k] = 1'b1;
				end
				if ((nrm_s[k-1].rem_y >> (30 - k)) >= {12'd0, dvy_q}) begin
					nd.rem_y = nrm_s[k-1].rem_y - ({12'd0, dvy_q} << (30 - k));
					nd.q_y[30-k] = 1'b1;
				end
				nrm_s[k] <= nd;
			end
		end
	end

	// ---------------- magnitude, squares, r2 ----------------
	always_ff @(posedge clk) begin
		logic [SUM_W-1:0] sum;
		if (ce) begin
			mx_mg_s <= (nrm_s[30].sat_x || nrm_s[30].q_x > MAG_CAP) ? MAG_CAP : nrm_s[30].q_x;
			my_mg_s <= (nrm_s[30].sat_y || nrm_s[30].q_y > MAG_CAP) ? MAG_CAP : nrm_s[30].q_y;
			nx_mg_s <= nrm_s[30].neg_x;
			ny_mg_s <= nrm_s[30].neg_y;

			px_sq_s <= mx_mg_s * mx_mg_s;
			py_sq_s <= my_mg_s * my_mg_s;
			mx_sq_s <= mx_mg_s;
			my_sq_s <= my_mg_s;
			nx_sq_s <= nx_mg_s;
			ny_sq_s <= ny_mg_s;

			sum = px_sq_s + py_sq_s;
			rt_s[0].rem     <= sum;
			rt_s[0].root    <= '0;
			rt_s[0].mx      <= mx_sq_s;
			rt_s[0].my      <= my_sq_s;
			rt_s[0].neg_x   <= nx_sq_s;
			rt_s[0].neg_y   <= ny_sq_s;
			rt_s[0].r2      <= (sum[57:56] != 2'b00) ? R2_MAX : sum[55:32];
			rt_s[0].in_disc <= (sum[57:56] == 2'b00) && (sum[55:32] <= R2_ONE);
		end
	end

	// ---------------- square root, one root bit per stage ----------------
	always_ff @(posedge clk) begin
		logic [SUM_W:0] t;
		rt_t rd;
		if (ce) begin
			for (int k = 1; k <= 29; k++) begin
				t = ({30'd0, rt_s[k-1].root} << (30 - k)) | (59'd1 << (2 * (29 - k)));
				rd = rt_s[k-1];
				if ({1'b0, rt_s[k-1].rem} >= t) begin
					rd.rem = rt_s[k-1].rem - t[SUM_W-1:0];
					rd.root[29-k] = 1'b1;
				end
				rt_s[k] <= rd;
			end
		end
	end

	// ---------------- polar angle and reduction ----------------
	always_ff @(posedge clk) begin
		logic [24:0] rc;
		logic [49:0] pf;
		logic [61:0] th;
		if (ce) begin
			rc = (rt_s[29].root > MAG_W'(ROOT_CAP)) ? ROOT_CAP : rt_s[29].root[24:0];
			pf = rc * fov_q;
			psi_ps_s        <= pf[48:24];
			sd_ps_s.mx      <= rt_s[29].mx;
			sd_ps_s.my      <= rt_s[29].my;
			sd_ps_s.neg_x   <= rt_s[29].neg_x;
			sd_ps_s.neg_y   <= rt_s[29].neg_y;
			sd_ps_s.r2      <= rt_s[29].r2;
			sd_ps_s.in_disc <= rt_s[29].in_disc;
			sd_ps_s.root    <= rt_s[29].root;

			// psi stays below twice a full turn
			psi_wr_s <= (psi_ps_s >= DEG360) ? psi_ps_s - DEG360 : psi_ps_s;
			sd_wr_s  <= sd_ps_s;

			if (psi_wr_s < DEG90) begin
				quad_qd_s <= 2'd0;
				rem_qd_s  <= psi_wr_s[22:0];
			end else if (psi_wr_s < DEG180) begin
				quad_qd_s <= 2'd1;
				rem_qd_s  <= 23'(psi_wr_s - DEG90);
			end else if (psi_wr_s < DEG270) begin
				quad_qd_s <= 2'd2;
				rem_qd_s  <= 23'(psi_wr_s - DEG180);
			end else begin
				quad_qd_s <= 2'd3;
				rem_qd_s  <= 23'(psi_wr_s - DEG270);
			end
			sd_qd_s <= sd_wr_s;

			phi_t1_s  <= rem_qd_s * RAD_HI;
			plo_t1_s  <= rem_qd_s * RAD_LO;
			quad_t1_s <= quad_qd_s;
			sd_t1_s   <= sd_qd_s;

			th = {phi_t1_s, 20'd0} + {19'd0, plo_t1_s};
			cor_s[0].x    <= CORDIC_GAIN;
			cor_s[0].y    <= '0;
			cor_s[0].z    <= {2'b00, th[60:30]};
			cor_s[0].quad <= quad_t1_s;
			cor_s[0].side <= sd_t1_s;
		end
	end

	// ---------------- CORDIC rotation, one iteration per stage ----------------
	always_ff @(posedge clk) begin
		cor_t cd;
		if (ce) begin
			for (int k = 0; k < NI; k++) begin
				cd = cor_s[k];
				if (!cor_s[k].z[CRD_W-1]) begin
					cd.x = $signed(cor_s[k].x) - ($signed(cor_s[k].y) >>> k);
					cd.y = $signed(cor_s[k].y) + ($signed(cor_s[k].x) >>> k);
					cd.z = $signed(cor_s[k].z) - atan_step(k);
				end else begin
					cd.x = $signed(cor_s[k].x) + ($signed(cor_s[k].y) >>> k);
					cd.y = $signed(cor_s[k].y) - ($signed(cor_s[k].x) >>> k);
					cd.z = $signed(cor_s[k].z) + atan_step(k);
				end
				cor_s[k+1] <= cd;
			end
		end
	end

	// ---------------- quadrant map, products, alpha divider ----------------
	always_ff @(posedge clk) begin
		logic signed [TRM_W-1:0] c, s;
		logic [30:0] as;
		logic [59:0] pa, pb;
		qt_t qn;
		if (ce) begin
			c = clamp_q30(cor_s[NI].x);
			s = clamp_q30(cor_s[NI].y);
			case (cor_s[NI].quad)
				2'd0: begin cp_cl_s <= c;  sp_cl_s <= s;  end
				2'd1: begin cp_cl_s <= -s; sp_cl_s <= c;  end
				2'd2: begin cp_cl_s <= -c; sp_cl_s <= -s; end
				default: begin cp_cl_s <= s; sp_cl_s <= -c; end
			endcase
			sd_cl_s <= cor_s[NI].side;

			as = sp_cl_s[TRM_W-1] ? 31'(-sp_cl_s) : 31'(sp_cl_s);
			pa = as * sd_cl_s.mx;
			pb = as * sd_cl_s.my;
			qt_s[0].rem_a   <= pa[PRD_W-1:0];
			qt_s[0].rem_b   <= pb[PRD_W-1:0];
			qt_s[0].q_a     <= '0;
			qt_s[0].q_b     <= '0;
			qt_s[0].neg_a   <= sp_cl_s[TRM_W-1] ^ sd_cl_s.neg_x;
			qt_s[0].neg_b   <= sp_cl_s[TRM_W-1] ^ sd_cl_s.neg_y;
			qt_s[0].cp      <= cp_cl_s;
			qt_s[0].root    <= sd_cl_s.root;
			qt_s[0].r2      <= sd_cl_s.r2;
			qt_s[0].in_disc <= sd_cl_s.in_disc;

			// magnitude never exceeds the root inside the disc, so 31 bits suffice
			for (int k = 1; k <= 31; k++) begin
				qn = qt_s[k-1];
				if ((qt_s[k-1].rem_a >> (31 - k)) >= {30'd0, qt_s[k-1].root}) begin
					qn.rem_a = qt_s[k-1].rem_a - ({30'd0, qt_s[k-1].root} << (31 - k));
					qn.q_a[31-k] = 1'b1;
				end
				if ((qt_s[k-1].rem_b >> (31 - k)) >= {30'd0, qt_s[k-1].root}) begin
					qn.rem_b = qt_s[k-1].rem_b - ({30'd0, qt_s[k-1].root} << (31 - k));
					qn.q_b[31-k] = 1'b1;
				end
				qt_s[k] <= qn;
			end
		end
	end

	// ---------------- basis combination, rounding, saturation ----------------
	always_ff @(posedge clk) begin
		logic [QUO_W-1:0] qa, qb;
		logic signed [TRM_W-1:0] a, b;
		logic signed [53:0] rnd;
		logic signed [23:0] dq;
		logic [19:0] dv [3];
		if (ce) begin
			// centre point: both alpha terms vanish
			qa = (qt_s[31].root == '0) ? '0 :
				(qt_s[31].q_a > ONE_Q30_U ? ONE_Q30_U : qt_s[31].q_a);
			qb = (qt_s[31].root == '0) ? '0 :
				(qt_s[31].q_b > ONE_Q30_U ? ONE_Q30_U : qt_s[31].q_b);
			a = qt_s[31].neg_a ? -$signed({1'b0, qa}) : $signed({1'b0, qa});
			b = qt_s[31].neg_b ? -$signed({1'b0, qb}) : $signed({1'b0, qb});
			for (int k = 0; k < 3; k++) begin
				mu_ml_s[k] <= a * $signed(bu_q[20*k +: 20]);
				mv_ml_s[k] <= b * $signed(bv_q[20*k +: 20]);
				mw_ml_s[k] <= qt_s[31].cp * $signed(bw_q[20*k +: 20]);
			end
			r2_ml_s <= qt_s[31].r2;
			in_ml_s <= qt_s[31].in_disc;

			for (int k = 0; k < 3; k++)
				acc_ac_s[k] <= mu_ml_s[k] + mv_ml_s[k] - mw_ml_s[k];
			r2_ac_s <= r2_ml_s;
			in_ac_s <= in_ml_s;

			for (int k = 0; k < 3; k++) begin
				rnd = acc_ac_s[k] + 54'sd536870912;
				dq  = 24'(rnd >>> 30);
				if (!in_ac_s)
					dv[k] = '0;
				else if (dq > 24'sd524287)
					dv[k] = 20'h7FFFF;
				else if (dq < -24'sd524288)
					dv[k] = 20'h80000;
				else
					dv[k] = dq[19:0];
			end
			p_data_s <= {4'd0, r2_ac_s, dv[2], dv[1], dv[0]};
			p_user_s <= in_ac_s;
		end
	end

	// ---------------- output register and skid buffer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q  <= skid_valid_q || (ce && vld_s[DEPTH-1]);
			skid_valid_q <= 1'b0;
		end else if (ce && vld_s[DEPTH-1]) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_tready) begin
			out_data_q <= skid_valid_q ? skid_data_q : p_data_s;
			out_user_q <= skid_valid_q ? skid_user_q : p_user_s;
		end else if (ce) begin
			skid_data_q <= p_data_s;
			skid_user_q <= p_user_s;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	// ---------------- checks ----------------
	`FRD_ASSERT_IMPL(a_skid_behind_out, clk, arst_n, skid_valid_q, out_valid_q)
	`FRD_ASSERT_IMPL(a_skid_only_on_stall, clk, arst_n, $rose(skid_valid_q),
		$past(out_valid_q && !m_tready))
	`FRD_ASSERT_IMPL(a_outside_zero, clk, arst_n, out_valid_q && !out_user_q,
		out_data_q[59:0] == 60'd0)
	`FRD_ASSERT_IMPL(a_flag_matches_r2, clk, arst_n, out_valid_q,
		out_user_q == (out_data_q[83:60] <= R2_ONE))

endmodule
